>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define RNTA_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("rnta check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define RNTA_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("rnta check failed");

`endif

>>> rtl/rnta_pkg.sv
// types, constants and helpers for the radix number to ascii converter
`default_nettype none

package rnta_pkg;

  localparam int ValueW    = 64;
  localparam int DigW      = 4;
  localparam int NumDig    = 22;
  localparam int BcdW      = NumDig * DigW;
  localparam int CntW      = $clog2(NumDig + 1);
  localparam int DabSteps  = 4;
  localparam int DabCycles = ValueW / DabSteps;
  localparam int DabCntW   = $clog2(DabCycles);

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiAlpha = 8'h57;
  localparam logic [7:0] AsciiMinus = 8'h2d;

  typedef enum logic [1:0] {
    KIND_DEC  = 2'd0,
    KIND_OCT  = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic top_zero;
    logic one_left;
    logic neg;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] glyph(input logic [DigW-1:0] d);
    logic [7:0] d8;
    d8 = {{(8-DigW){1'b0}}, d};
    if (d < DigW'(10)) begin
      return AsciiZero + d8;
    end else begin
      return AsciiAlpha + d8;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/rnta_ctrl.sv
// control state machine of the radix number to ascii converter
`default_nettype none

module rnta_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           kind,
  output logic                      in_ready,
  input  wire rnta_pkg::stat_t      stat,
  output rnta_pkg::cmd_t            cmd
);

  rnta_pkg::state_t                  state;
  rnta_pkg::state_t                  state_next;
  logic [rnta_pkg::DabCntW-1:0]      dab_cnt;
  logic [rnta_pkg::DabCntW-1:0]      dab_cnt_next;
  logic                              conv_done;
  logic                              skip_more;

  assign conv_done = (dab_cnt == rnta_pkg::DabCntW'(rnta_pkg::DabCycles - 1));
  // leading zero that is not the only remaining digit
  assign skip_more = stat.top_zero && !stat.one_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rnta_pkg::ST_IDLE;
      dab_cnt <= '0;
    end else begin
      state   <= state_next;
      dab_cnt <= dab_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rnta_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (rnta_pkg::kind_t'(kind))
            rnta_pkg::KIND_DEC: state_next = rnta_pkg::ST_CONV;
            rnta_pkg::KIND_OCT,
            rnta_pkg::KIND_HEX: state_next = rnta_pkg::ST_SKIP;
            default:            state_next = rnta_pkg::ST_IDLE;
          endcase
        end
      end
      rnta_pkg::ST_CONV: begin
        if (conv_done) begin
          state_next = rnta_pkg::ST_SKIP;
        end
      end
      rnta_pkg::ST_SKIP: begin
        if (!skip_more) begin
          state_next = rnta_pkg::ST_EMIT;
        end
      end
      rnta_pkg::ST_EMIT: begin
        if (stat.out_free && !stat.neg && stat.one_left) begin
          state_next = rnta_pkg::ST_IDLE;
        end
      end
      default: state_next = rnta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    dab_cnt_next = dab_cnt;
    unique case (state)
      rnta_pkg::ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        cmd.load = in_valid && !rst && (kind != rnta_pkg::KIND_NONE);
      end
      rnta_pkg::ST_CONV: begin
        cmd.dabble   = 1'b1;
        dab_cnt_next = dab_cnt + rnta_pkg::DabCntW'(1);
      end
      rnta_pkg::ST_SKIP: begin
        cmd.shift = skip_more;
      end
      rnta_pkg::ST_EMIT: begin
        cmd.emit_sign  = stat.out_free && stat.neg;
        cmd.emit_digit = stat.out_free && !stat.neg;
        cmd.shift      = stat.out_free && !stat.neg;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rnta_dp.sv
// datapath of the radix number to ascii converter: digit register and output stage
`default_nettype none

module rnta_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    kind,
  input  wire logic [rnta_pkg::ValueW-1:0]   value,
  input  wire rnta_pkg::cmd_t                cmd,
  output rnta_pkg::stat_t                    stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         ascii_char,
  output logic                               last
);

  localparam int BcdW = rnta_pkg::BcdW;
  localparam int DigW = rnta_pkg::DigW;

  logic [rnta_pkg::ValueW-1:0]  bin;
  logic [BcdW-1:0]              bcd;
  logic [rnta_pkg::CntW-1:0]    cnt;
  logic                         neg;
  logic                         is_neg;
  logic [BcdW-1:0]              dab_bcd;
  logic [rnta_pkg::ValueW-1:0]  dab_bin;
  logic [BcdW-1:0]              oct_dig;
  logic [DigW-1:0]              top_dig;

  assign top_dig = bcd[BcdW-1 -: DigW];
  assign is_neg  = (kind == rnta_pkg::KIND_DEC) && value[rnta_pkg::ValueW-1];

  assign stat.top_zero = (top_dig == '0);
  assign stat.one_left = (cnt == rnta_pkg::CntW'(1));
  assign stat.neg      = neg;
  assign stat.out_free = !out_valid || out_ready;

  // octal digits widened to one nibble each, top digit holds the last bit
  always_comb begin
    oct_dig = '0;
    for (int d = 0; d < rnta_pkg::NumDig - 1; d++) begin
      oct_dig[d*DigW +: DigW] = {1'b0, value[d*3 +: 3]};
    end
    oct_dig[BcdW-1 -: DigW] = {{(DigW-1){1'b0}}, value[rnta_pkg::ValueW-1]};
  end

  // shift-and-add-3, several bits per cycle
  always_comb begin
    dab_bcd = bcd;
    dab_bin = bin;
    for (int s = 0; s < rnta_pkg::DabSteps; s++) begin
      for (int d = 0; d < rnta_pkg::NumDig; d++) begin
        if (dab_bcd[d*DigW +: DigW] >= DigW'(5)) begin
          dab_bcd[d*DigW +: DigW] = dab_bcd[d*DigW +: DigW] + DigW'(3);
        end
      end
      dab_bcd = {dab_bcd[BcdW-2:0], dab_bin[rnta_pkg::ValueW-1]};
      dab_bin = {dab_bin[rnta_pkg::ValueW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= is_neg;
      cnt <= rnta_pkg::CntW'(rnta_pkg::NumDig);
      unique case (rnta_pkg::kind_t'(kind))
        rnta_pkg::KIND_DEC: begin
          bin <= is_neg ? (rnta_pkg::ValueW'(0) - value) : value;
          bcd <= '0;
        end
        rnta_pkg::KIND_OCT: begin
          bin <= '0;
          bcd <= oct_dig;
        end
        default: begin
          bin <= '0;
          bcd <= {{(BcdW-rnta_pkg::ValueW){1'b0}}, value};
        end
      endcase
    end else begin
      if (cmd.dabble) begin
        bin <= dab_bin;
        bcd <= dab_bcd;
      end
      if (cmd.shift) begin
        bcd <= {bcd[BcdW-DigW-1:0], {DigW{1'b0}}};
        cnt <= cnt - rnta_pkg::CntW'(1);
      end
      if (cmd.emit_sign) begin
        neg <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      ascii_char <= rnta_pkg::AsciiMinus;
      last       <= 1'b0;
    end else if (cmd.emit_digit) begin
      ascii_char <= rnta_pkg::glyph(top_dig);
      last       <= (cnt == rnta_pkg::CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/radix_number_to_ascii_core.sv
// top level of the radix number to ascii converter
`default_nettype none

// Converts one 64-bit value per item into ASCII text, most significant digit
// first, one character per output item, with last set on the final character.
// kind selects signed decimal (a negative value gives '-' then its magnitude),
// unsigned octal or unsigned lower-case hex; kind three is taken and dropped
// with no output. Zero gives a single '0' and leading zeros never appear.
// The 22-digit register is walked one digit a cycle from the top: leading
// zeros are dropped, then one character is emitted a cycle while the output
// is not stalled. For decimal, the shift-and-add-3 unit first turns 4 input
// bits a cycle into BCD. The final character sits in the output register
// while the next item is accepted.
module radix_number_to_ascii_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  kind,
  input  wire logic [rnta_pkg::ValueW-1:0] value,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       ascii_char,
  output logic                             last
);

  // commands from the controller, status back from the datapath
  rnta_pkg::cmd_t  cmd;
  rnta_pkg::stat_t stat;

  // sequencer: load, bcd conversion, leading zero skip, character emit
  rnta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // digit register, magnitude/bcd unit and output register
  rnta_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .kind       (kind),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ascii_char (ascii_char),
    .last       (last)
  );

endmodule

`default_nettype wire

>>> rtl/rnta_checker.sv
// port-level checks for the radix number to ascii converter, with its bind
`default_nettype none

`include "assert_macros.svh"

module rnta_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  kind,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  ascii_char,
  input wire logic        last
);

  logic legal_char;
  logic item_taken;
  logic out_stall;

  assign legal_char = (ascii_char >= 8'h30 && ascii_char <= 8'h39) ||
                      (ascii_char >= 8'h61 && ascii_char <= 8'h66) ||
                      (ascii_char == rnta_pkg::AsciiMinus);
  assign item_taken = in_valid && in_ready && (kind != rnta_pkg::KIND_NONE);
  assign out_stall  = out_valid && !out_ready;

  // a stalled character holds
  `RNTA_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(ascii_char) && $stable(last))
  // a real item blocks input until its text is out
  `RNTA_ASSERT_NXT(a_busy_after_take, item_taken, !in_ready)
  // only digits, lower-case hex letters and the minus sign
  `RNTA_ASSERT_IMP(a_legal_char, out_valid, legal_char)
  // the sign is always followed by digits
  `RNTA_ASSERT_IMP(a_sign_not_last, out_valid && ascii_char == rnta_pkg::AsciiMinus, !last)

endmodule

bind radix_number_to_ascii_core rnta_checker u_rnta_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .kind       (kind),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .ascii_char (ascii_char),
  .last       (last)
);

`default_nettype wire
